>>> hw/rtl/a3d_pkg.sv
// ----------------------------------------------------------------------------
// a3d_pkg: shared types and constants of the affine 3-D transform engine
// Fixed-point format, action codes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package a3d_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ANG_W     = 18;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int ACT_W     = 3;
    localparam int MAT_N     = 12;
    localparam int UU_N      = 6;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam word_t ONE_Q = word_t'(1) <<< FRAC_BITS;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_IDENT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TRANSLATE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SCALE     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ROTATE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_VERTEX    = 3'd4;

    // Rotation passes: pre-translate, rotate, post-translate
    localparam logic [1:0] PASS_PRE  = 2'd0;
    localparam logic [1:0] PASS_ROT  = 2'd1;
    localparam logic [1:0] PASS_POST = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCL,
        ST_UU,
        ST_ROT,
        ST_MAT,
        ST_COPY,
        ST_VTX
    } fsm_t;

    // Clamp a wide sum to the signed word range
    function automatic word_t sat_word(acc_t v);
        acc_t max_v;
        acc_t min_v;
        max_v = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        min_v = ~max_v;
        if (v > max_v)
            return max_v[DATA_W-1:0];
        else if (v < min_v)
            return min_v[DATA_W-1:0];
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

>>> hw/rtl/affine_3d_transform_engine.sv
// ----------------------------------------------------------------------------
// affine_3d_transform_engine: composite 3x4 affine matrix with vertex mapping
// Keeps a Q16.16 matrix, premultiplies it by translate, scale and rotate
// requests and maps vertices through it on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//
//  channel | signals                                            | handshake
//  --------+----------------------------------------------------+-------------------
//  input   | action, arg_*, pivot_*, cos/sin_angle, last_vertex | in_valid/in_ready
//  output  | out_x, out_y, out_z, out_last                      | out_valid/out_ready
//
//  Every product runs through one registered multiplier; each result word has
//  3 product slots, then the final add and clamp.
//  A rotate request runs three matrix products plus the axis terms.
//  in_ready is high only while the sequencer is idle.
//  A finished vertex waits in the output register; a following vertex
//  stalls on its last cycle until that result is taken.
//  Reset loads the identity matrix.

module affine_3d_transform_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [a3d_pkg::ACT_W-1:0]        action,
    input  logic signed [a3d_pkg::DATA_W-1:0] arg_x,
    input  logic signed [a3d_pkg::DATA_W-1:0] arg_y,
    input  logic signed [a3d_pkg::DATA_W-1:0] arg_z,
    input  logic signed [a3d_pkg::DATA_W-1:0] pivot_x,
    input  logic signed [a3d_pkg::DATA_W-1:0] pivot_y,
    input  logic signed [a3d_pkg::DATA_W-1:0] pivot_z,
    input  logic signed [a3d_pkg::ANG_W-1:0]  cos_angle,
    input  logic signed [a3d_pkg::ANG_W-1:0]  sin_angle,
    input  logic                             last_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [a3d_pkg::DATA_W-1:0] out_x,
    output logic signed [a3d_pkg::DATA_W-1:0] out_y,
    output logic signed [a3d_pkg::DATA_W-1:0] out_z,
    output logic                             out_last
);

    a3d_pkg::fsm_t state_reg, state_next;

    logic [a3d_pkg::ACT_W-1:0] act_reg;
    logic [1:0]                pass_reg;
    logic [1:0]                k_reg;
    logic [1:0]                row_reg;
    logic [1:0]                col_reg;
    logic [2:0]                elem_reg;

    a3d_pkg::word_t a_reg [3];
    a3d_pkg::word_t p_reg [3];
    a3d_pkg::word_t cs_reg;
    a3d_pkg::word_t sn_reg;
    a3d_pkg::word_t oc_reg;
    logic           last_reg;

    a3d_pkg::word_t m_reg [a3d_pkg::MAT_N];
    a3d_pkg::word_t t_reg [a3d_pkg::MAT_N];
    a3d_pkg::word_t f_reg [a3d_pkg::MAT_N];
    a3d_pkg::word_t s_reg [a3d_pkg::UU_N];
    a3d_pkg::word_t f_load [a3d_pkg::MAT_N];
    a3d_pkg::word_t res_reg [2];

    a3d_pkg::prod_t prod_reg, prod_next;
    logic           neg_reg;
    a3d_pkg::acc_t  acc_reg;
    a3d_pkg::acc_t  term;
    a3d_pkg::word_t fin_word;

    a3d_pkg::word_t out_x_reg, out_y_reg, out_z_reg;
    logic           out_last_reg;
    logic           out_valid_reg;

    // Operand, address and rotation-helper control signals
    a3d_pkg::word_t mul_a, mul_b, bias;
    logic           mul_neg;
    logic [3:0]     f_addr, m_addr;
    logic [2:0]     s_addr;
    logic [1:0]     uu_r, uu_c, oth;
    logic           rot_neg;
    a3d_pkg::word_t f_rd, m_rd, s_rd;

    logic in_fire;
    logic computing;
    logic step_done;
    logic stall;
    logic vtx_done;

    assign in_ready  = (state_reg == a3d_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign computing = (state_reg == a3d_pkg::ST_SCL) || (state_reg == a3d_pkg::ST_UU)
                    || (state_reg == a3d_pkg::ST_ROT) || (state_reg == a3d_pkg::ST_MAT)
                    || (state_reg == a3d_pkg::ST_VTX);
    assign step_done = computing && (k_reg == 2'd3);
    assign stall     = (state_reg == a3d_pkg::ST_VTX) && (row_reg == 2'd2)
                    && (k_reg == 2'd3) && out_valid_reg && !out_ready;
    assign vtx_done  = (state_reg == a3d_pkg::ST_VTX) && (row_reg == 2'd2)
                    && (k_reg == 2'd3) && !stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            a3d_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((action == a3d_pkg::ACT_TRANSLATE) || (action == a3d_pkg::ACT_SCALE)
                        || (action == a3d_pkg::ACT_ROTATE))
                        state_next = a3d_pkg::ST_LOAD;
                    else if (action == a3d_pkg::ACT_VERTEX)
                        state_next = a3d_pkg::ST_VTX;
                end
            end
            a3d_pkg::ST_LOAD:
            begin
                if (act_reg == a3d_pkg::ACT_SCALE)
                    state_next = a3d_pkg::ST_SCL;
                else if ((act_reg == a3d_pkg::ACT_ROTATE) && (pass_reg == a3d_pkg::PASS_ROT))
                    state_next = a3d_pkg::ST_ROT;
                else
                    state_next = a3d_pkg::ST_MAT;
            end
            a3d_pkg::ST_SCL:
                if (step_done && (row_reg == 2'd2))
                    state_next = a3d_pkg::ST_MAT;
            a3d_pkg::ST_UU:
                if (step_done && (elem_reg == 3'd5))
                    state_next = a3d_pkg::ST_LOAD;
            a3d_pkg::ST_ROT:
                if (step_done && (row_reg == 2'd2) && (col_reg == 2'd2))
                    state_next = a3d_pkg::ST_MAT;
            a3d_pkg::ST_MAT:
                if (step_done && (row_reg == 2'd2) && (col_reg == 2'd3))
                    state_next = a3d_pkg::ST_COPY;
            a3d_pkg::ST_COPY:
            begin
                if ((act_reg == a3d_pkg::ACT_ROTATE) && (pass_reg == a3d_pkg::PASS_PRE))
                    state_next = a3d_pkg::ST_UU;
                else if ((act_reg == a3d_pkg::ACT_ROTATE) && (pass_reg == a3d_pkg::PASS_ROT))
                    state_next = a3d_pkg::ST_LOAD;
                else
                    state_next = a3d_pkg::ST_IDLE;
            end
            a3d_pkg::ST_VTX:
                if (vtx_done)
                    state_next = a3d_pkg::ST_IDLE;
            default:
                state_next = a3d_pkg::ST_IDLE;
        endcase
    end

    // Axis-product pair for the current element
    always_comb
    begin
        unique case (elem_reg)
            3'd1:    begin uu_r = 2'd1; uu_c = 2'd1; end
            3'd2:    begin uu_r = 2'd2; uu_c = 2'd2; end
            3'd3:    begin uu_r = 2'd0; uu_c = 2'd1; end
            3'd4:    begin uu_r = 2'd0; uu_c = 2'd2; end
            3'd5:    begin uu_r = 2'd1; uu_c = 2'd2; end
            default: begin uu_r = 2'd0; uu_c = 2'd0; end
        endcase
    end

    // Rotation helpers: remaining axis index, sign of its sine term and axis-product address
    assign oth     = 2'd3 - row_reg - col_reg;
    assign rot_neg = (col_reg == ((row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1));
    assign s_addr  = (row_reg == col_reg) ? {1'b0, row_reg}
                                          : 3'({1'b0, row_reg} + {1'b0, col_reg} + 3'd2);

    // Register file reads
    assign f_rd = f_reg[f_addr];
    assign m_rd = m_reg[m_addr];
    assign s_rd = s_reg[s_addr];

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        bias    = '0;
        f_addr  = {row_reg, k_reg};
        m_addr  = {row_reg, k_reg};
        unique case (state_reg)
            a3d_pkg::ST_SCL:
            begin
                f_addr = {row_reg, 2'd3};
                if (k_reg == 2'd0)
                begin
                    mul_a = f_rd;
                    mul_b = p_reg[row_reg];
                end
            end
            a3d_pkg::ST_UU:
            begin
                if (k_reg == 2'd0)
                begin
                    mul_a = a_reg[uu_r];
                    mul_b = a_reg[uu_c];
                end
            end
            a3d_pkg::ST_ROT:
            begin
                if (k_reg == 2'd0)
                begin
                    mul_a = s_rd;
                    mul_b = oc_reg;
                end
                else if ((k_reg == 2'd1) && (row_reg != col_reg))
                begin
                    mul_a   = a_reg[oth];
                    mul_b   = sn_reg;
                    mul_neg = rot_neg;
                end
                if ((k_reg == 2'd3) && (row_reg == col_reg))
                    bias = cs_reg;
            end
            a3d_pkg::ST_MAT:
            begin
                m_addr = (k_reg == 2'd3) ? 4'd0 : {k_reg, col_reg};
                if (k_reg != 2'd3)
                begin
                    mul_a = f_rd;
                    mul_b = m_rd;
                end
                else if (col_reg == 2'd3)
                    bias = f_rd;
            end
            a3d_pkg::ST_VTX:
            begin
                if (k_reg != 2'd3)
                begin
                    mul_a = m_rd;
                    mul_b = a_reg[k_reg];
                end
                else
                    bias = m_rd;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Multiply, floor shift and accumulate
    assign prod_next = mul_a * mul_b;
    assign term      = neg_reg ? -a3d_pkg::acc_t'(prod_reg >>> a3d_pkg::FRAC_BITS)
                               :  a3d_pkg::acc_t'(prod_reg >>> a3d_pkg::FRAC_BITS);
    assign fin_word  = a3d_pkg::sat_word(acc_reg + term + a3d_pkg::acc_t'(bias));

    // Elementary matrix contents loaded before a product
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                f_load[r*4+c] = '0;
                if (c == r)
                begin
                    if (act_reg == a3d_pkg::ACT_SCALE)
                        f_load[r*4+c] = a_reg[r];
                    else if (!((act_reg == a3d_pkg::ACT_ROTATE)
                               && (pass_reg == a3d_pkg::PASS_ROT)))
                        f_load[r*4+c] = a3d_pkg::ONE_Q;
                end
                else if (c == 3)
                begin
                    if (act_reg == a3d_pkg::ACT_TRANSLATE)
                        f_load[r*4+c] = a_reg[r];
                    else if (act_reg == a3d_pkg::ACT_SCALE)
                        f_load[r*4+c] = a3d_pkg::sat_word(a3d_pkg::acc_t'(a3d_pkg::ONE_Q)
                                                          - a3d_pkg::acc_t'(a_reg[r]));
                    else if (pass_reg == a3d_pkg::PASS_PRE)
                        f_load[r*4+c] = a3d_pkg::sat_word(-a3d_pkg::acc_t'(p_reg[r]));
                    else if (pass_reg == a3d_pkg::PASS_POST)
                        f_load[r*4+c] = p_reg[r];
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= a3d_pkg::ST_IDLE;
            act_reg       <= a3d_pkg::ACT_IDENT;
            pass_reg      <= a3d_pkg::PASS_PRE;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            elem_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                act_reg  <= action;
                pass_reg <= a3d_pkg::PASS_PRE;
                k_reg    <= '0;
                row_reg  <= '0;
                col_reg  <= '0;
                elem_reg <= '0;
            end
            // Rotation pass bookkeeping
            if ((state_reg == a3d_pkg::ST_UU) && (state_next == a3d_pkg::ST_LOAD))
                pass_reg <= a3d_pkg::PASS_ROT;
            if ((state_reg == a3d_pkg::ST_COPY) && (pass_reg == a3d_pkg::PASS_ROT))
                pass_reg <= a3d_pkg::PASS_POST;
            // Element and term counters
            if (computing && !stall)
            begin
                k_reg <= k_reg + 2'd1;
                if (step_done)
                begin
                    unique case (state_reg)
                        a3d_pkg::ST_UU:
                            elem_reg <= (elem_reg == 3'd5) ? 3'd0 : elem_reg + 3'd1;
                        a3d_pkg::ST_ROT:
                        begin
                            col_reg <= (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                            if (col_reg == 2'd2)
                                row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                        end
                        a3d_pkg::ST_MAT:
                        begin
                            col_reg <= col_reg + 2'd1;
                            if (col_reg == 2'd3)
                                row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                        end
                        default:
                            row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                    endcase
                end
            end
            // Output handshake
            if (vtx_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Composite matrix: identity at reset or on an identity action, else copied from the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < a3d_pkg::MAT_N; i++)
                m_reg[i] <= ((i % 5) == 0) ? a3d_pkg::ONE_Q : '0;
        end
        else if (in_fire && (action == a3d_pkg::ACT_IDENT))
        begin
            for (int i = 0; i < a3d_pkg::MAT_N; i++)
                m_reg[i] <= ((i % 5) == 0) ? a3d_pkg::ONE_Q : '0;
        end
        else if (state_reg == a3d_pkg::ST_COPY)
        begin
            for (int i = 0; i < a3d_pkg::MAT_N; i++)
                m_reg[i] <= t_reg[i];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg[0] <= arg_x;
            a_reg[1] <= arg_y;
            a_reg[2] <= arg_z;
            p_reg[0] <= pivot_x;
            p_reg[1] <= pivot_y;
            p_reg[2] <= pivot_z;
            cs_reg   <= a3d_pkg::word_t'(cos_angle);
            sn_reg   <= a3d_pkg::word_t'(sin_angle);
            oc_reg   <= a3d_pkg::sat_word(a3d_pkg::acc_t'(a3d_pkg::ONE_Q)
                                          - a3d_pkg::acc_t'(cos_angle));
            last_reg <= last_vertex;
        end
        if (!stall)
        begin
            prod_reg <= prod_next;
            neg_reg  <= mul_neg;
            if (k_reg == 2'd1)
                acc_reg <= term;
            else if (k_reg == 2'd2)
                acc_reg <= acc_reg + term;
        end
        if (state_reg == a3d_pkg::ST_LOAD)
        begin
            for (int i = 0; i < a3d_pkg::MAT_N; i++)
                f_reg[i] <= f_load[i];
        end
        // Final write of each element
        if (step_done && !stall)
        begin
            unique case (state_reg)
                a3d_pkg::ST_SCL: f_reg[{row_reg, 2'd3}]   <= fin_word;
                a3d_pkg::ST_UU:  s_reg[elem_reg]          <= fin_word;
                a3d_pkg::ST_ROT: f_reg[{row_reg, col_reg}] <= fin_word;
                a3d_pkg::ST_MAT: t_reg[{row_reg, col_reg}] <= fin_word;
                a3d_pkg::ST_VTX:
                begin
                    if (row_reg == 2'd2)
                    begin
                        out_x_reg    <= res_reg[0];
                        out_y_reg    <= res_reg[1];
                        out_z_reg    <= fin_word;
                        out_last_reg <= last_reg;
                    end
                    else
                        res_reg[row_reg[0]] <= fin_word;
                end
                default:
                    acc_reg <= acc_reg;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_last  = out_last_reg;

endmodule
